// ----- rtl/websocket_frame_parser_core_defines.svh -----
// assertion macros for the websocket frame parser rtl, used by the parser front
`ifndef WEBSOCKET_FRAME_PARSER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define WFP_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wfp assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define WFP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wfp assertion failed");

`endif

// ----- rtl/wfp_pkg.sv -----
// types and constants of the websocket frame parser
package wfp_pkg;

	typedef enum logic [4:0] {
		PH_HEAD0 = 5'b00001,
		PH_HEAD1 = 5'b00010,
		PH_LEN   = 5'b00100,
		PH_KEY   = 5'b01000,
		PH_DATA  = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CTRL_LEN = 2'd1,
		ST_BAD_OP   = 2'd2
	} status_t;

	// one classified transaction from the front to the back
	typedef struct packed {
		logic [7:0] data;
		logic [7:0] key;
		logic       has;
		logic       done;
		logic       ovf;
		logic [3:0] opcode;
		logic       fin;
	} rec_t;

	typedef struct packed {
		logic [7:0] payload;
		logic       has;
		logic [3:0] opcode;
		logic       fin;
		logic       done;
		status_t    status;
	} res_t;

	localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
	localparam logic [6:0] LEN7_EXT16    = 7'd126;
	localparam logic [6:0] LEN7_EXT64    = 7'd127;
	localparam logic [2:0] LEN16_BYTES_LEFT = 3'd1;
	localparam logic [2:0] LEN64_BYTES_LEFT = 3'd7;
	localparam logic [1:0] KEY_LAST = 2'd3;

	localparam logic [3:0] OPC_CONT   = 4'h0;
	localparam logic [3:0] OPC_BINARY = 4'h2;
	localparam logic [3:0] OPC_CLOSE  = 4'h8;
	localparam logic [3:0] OPC_PONG   = 4'hA;

	function automatic logic opcode_known(input logic [3:0] op);
		opcode_known = (op <= OPC_BINARY) || (op >= OPC_CLOSE && op <= OPC_PONG);
	endfunction

endpackage

// ----- rtl/wfp_front.sv -----
// header parser: classifies each byte and writes result records to the queue
`include "websocket_frame_parser_core_defines.svh"
module wfp_front #(
	parameter int LENGTH_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          accept,
	input  logic [7:0]    rx_byte,
	output logic          wr,
	output wfp_pkg::rec_t rec
);
	import wfp_pkg::*;

	phase_t                   phase_q, phase_d;
	logic                     fin_q, fin_d;
	logic [3:0]               opc_q, opc_d;
	logic                     masked_q, masked_d;
	logic [LENGTH_BITS-1:0]   len_q, len_d;
	logic [LENGTH_BITS-1:0]   cnt_q, cnt_d;
	logic [3:0][7:0]          key_q, key_d;
	logic [1:0]               idx_q, idx_d;
	logic [2:0]               len_left_q, len_left_d;
	logic [1:0]               key_cnt_q, key_cnt_d;

	logic                     hd;
	logic                     clear;
	logic [LENGTH_BITS-1:0]   cnt_inc;
	logic [LENGTH_BITS-1:0]   len_shift;

	assign cnt_inc   = cnt_q + LENGTH_BITS'(1);
	assign len_shift = {len_q[LENGTH_BITS-9:0], rx_byte};

	always_comb begin
		phase_d    = phase_q;
		fin_d      = fin_q;
		opc_d      = opc_q;
		masked_d   = masked_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		key_d      = key_q;
		idx_d      = idx_q;
		len_left_d = len_left_q;
		key_cnt_d  = key_cnt_q;
		hd         = 1'b0;
		clear      = 1'b0;
		wr         = 1'b0;
		rec.data   = rx_byte;
		rec.key    = key_q[idx_q];
		rec.has    = 1'b0;
		rec.done   = 1'b0;
		rec.ovf    = 1'b0;
		rec.opcode = opc_q;
		rec.fin    = fin_q;
		if (accept) begin
			case (phase_q)
				PH_HEAD1: begin
					masked_d = rx_byte[7];
					if (opc_q[3] && rx_byte[6:0] > LEN7_CTRL_MAX) begin
						wr       = 1'b1;
						rec.done = 1'b1;
						rec.ovf  = 1'b1;
						clear    = 1'b1;
					end else if (rx_byte[6:0] == LEN7_EXT16) begin
						len_d      = '0;
						len_left_d = LEN16_BYTES_LEFT;
						phase_d    = PH_LEN;
					end else if (rx_byte[6:0] == LEN7_EXT64) begin
						len_d      = '0;
						len_left_d = LEN64_BYTES_LEFT;
						phase_d    = PH_LEN;
					end else begin
						len_d = LENGTH_BITS'(rx_byte[6:0]);
						hd    = 1'b1;
					end
				end
				PH_LEN: begin
					len_d = len_shift;
					if (len_left_q == 3'd0) begin
						hd = 1'b1;
					end else begin
						len_left_d = len_left_q - 3'd1;
					end
				end
				PH_KEY: begin
					key_d[key_cnt_q] = rx_byte;
					key_cnt_d        = key_cnt_q + 2'd1;
					if (key_cnt_q == KEY_LAST) begin
						if (len_q == '0) begin
							wr       = 1'b1;
							rec.done = 1'b1;
							clear    = 1'b1;
						end else begin
							phase_d = PH_DATA;
							cnt_d   = '0;
							idx_d   = 2'd0;
						end
					end
				end
				PH_DATA: begin
					wr      = 1'b1;
					rec.has = 1'b1;
					cnt_d   = cnt_inc;
					idx_d   = idx_q + 2'd1;
					if (cnt_inc == len_q) begin
						rec.done = 1'b1;
						clear    = 1'b1;
					end
				end
				default: begin
					fin_d   = rx_byte[7];
					opc_d   = rx_byte[3:0];
					phase_d = PH_HEAD1;
				end
			endcase
			// end of header
			if (hd) begin
				if (masked_d) begin
					phase_d   = PH_KEY;
					key_cnt_d = 2'd0;
				end else if (len_d == '0) begin
					wr       = 1'b1;
					rec.done = 1'b1;
					clear    = 1'b1;
				end else begin
					phase_d = PH_DATA;
					cnt_d   = '0;
					idx_d   = 2'd0;
				end
			end
			if (clear) begin
				phase_d    = PH_HEAD0;
				fin_d      = 1'b0;
				opc_d      = 4'd0;
				masked_d   = 1'b0;
				len_d      = '0;
				cnt_d      = '0;
				key_d      = '0;
				idx_d      = 2'd0;
				len_left_d = 3'd0;
				key_cnt_d  = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEAD0;
			fin_q      <= 1'b0;
			opc_q      <= 4'd0;
			masked_q   <= 1'b0;
			len_q      <= '0;
			cnt_q      <= '0;
			key_q      <= '0;
			idx_q      <= 2'd0;
			len_left_q <= 3'd0;
			key_cnt_q  <= 2'd0;
		end else begin
			phase_q    <= phase_d;
			fin_q      <= fin_d;
			opc_q      <= opc_d;
			masked_q   <= masked_d;
			len_q      <= len_d;
			cnt_q      <= cnt_d;
			key_q      <= key_d;
			idx_q      <= idx_d;
			len_left_q <= len_left_d;
			key_cnt_q  <= key_cnt_d;
		end
	end

	`WFP_ASSERT_NOW(a_data_below_len, phase_q == PH_DATA, cnt_q < len_q)
	`WFP_ASSERT_NOW(a_unmasked_zero_key, phase_q == PH_DATA && !masked_q, key_q == '0)
	`WFP_ASSERT_NOW(a_ovf_ends_frame, wr && rec.ovf, rec.done && !rec.has)
	`WFP_ASSERT_NEXT(a_done_restarts, wr && rec.done, phase_q == PH_HEAD0 && len_q == '0)

endmodule

// ----- rtl/wfp_fifo.sv -----
// short register queue between the parser front and the output back
module wfp_fifo #(
	parameter int DEPTH = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  wfp_pkg::rec_t wr_data,
	input  logic          rd,
	output wfp_pkg::rec_t rd_data,
	output logic          full,
	output logic          empty
);
	import wfp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	rec_t            mem_q [DEPTH];
	logic [AW-1:0]   rd_ptr_q, wr_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

// ----- rtl/wfp_back.sv -----
// unmasks payload, forms the status and holds the result register
module wfp_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  wfp_pkg::rec_t q_data,
	output logic          q_rd,
	input  logic          pop,
	output logic          empty,
	output wfp_pkg::res_t res
);
	import wfp_pkg::*;

	logic valid_q;
	res_t res_q;
	res_t res_d;

	assign q_rd  = !q_empty && (!valid_q || pop);
	assign empty = !valid_q;
	assign res   = res_q;

	always_comb begin
		res_d.payload = q_data.has ? (q_data.data ^ q_data.key) : 8'd0;
		res_d.has     = q_data.has;
		res_d.opcode  = q_data.opcode;
		res_d.fin     = q_data.fin;
		res_d.done    = q_data.done;
		if (q_data.ovf) begin
			res_d.status = ST_CTRL_LEN;
		end else if (q_data.done && !opcode_known(q_data.opcode)) begin
			res_d.status = ST_BAD_OP;
		end else begin
			res_d.status = ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (q_rd) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_rd) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/websocket_frame_parser_core.sv -----
// top level of the websocket frame parser
//
//   channel   handshake        data
//   input     push / full      rx_byte
//   result    pop / empty      payload_byte, has_payload, frame_opcode,
//                              fin_flag, frame_done, status_code
//
// one byte accepted per cycle while full is low; a byte that gives a result passes the
// parser front and record queue into the output register, loaded when empty or popped
// the frame-end test is one LENGTH_BITS-wide increment and compare in the front
// full is the record queue full; header bytes that give no result still wait on it
// arst_n clears the parser and both queues; no clearing pass follows reset
module websocket_frame_parser_core #(
	parameter int LENGTH_BITS = 64,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] payload_byte,
	output logic       has_payload,
	output logic [3:0] frame_opcode,
	output logic       fin_flag,
	output logic       frame_done,
	output logic [1:0] status_code
);
	import wfp_pkg::*;

	logic accept;
	logic f_wr;
	rec_t f_rec;
	rec_t q_data;
	logic q_rd;
	logic q_empty;
	res_t res;

	assign accept = push && !full;

	wfp_front #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.rx_byte (rx_byte),
		.wr      (f_wr),
		.rec     (f_rec)
	);

	wfp_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (f_wr),
		.wr_data (f_rec),
		.rd      (q_rd),
		.rd_data (q_data),
		.full    (full),
		.empty   (q_empty)
	);

	wfp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_data),
		.q_rd    (q_rd),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign payload_byte = res.payload;
	assign has_payload  = res.has;
	assign frame_opcode = res.opcode;
	assign fin_flag     = res.fin;
	assign frame_done   = res.done;
	assign status_code  = res.status;

endmodule

// ----- dv/websocket_frame_parser_core_chk.sv -----
// checker for the websocket frame parser: predicts results per accepted byte and compares them
module websocket_frame_parser_core_chk (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic       full,
	input  logic [7:0] rx_byte,
	input  logic       empty,
	input  logic       pop,
	input  logic [7:0] payload_byte,
	input  logic       has_payload,
	input  logic [3:0] frame_opcode,
	input  logic       fin_flag,
	input  logic       frame_done,
	input  logic [1:0] status_code,
	output int         mismatches,
	output int         outstanding
);
	import wfp_pkg::*;

	localparam logic [3:0] OPC_TEXT = 4'h1;
	localparam logic [3:0] OPC_PING = 4'h9;
	localparam int MAX_REPORTS = 10;

	typedef enum logic [2:0] {
		P_FIRST,
		P_SECOND,
		P_EXTLEN,
		P_KEY,
		P_DATA
	} stage_t;

	stage_t      stage;
	logic        fin_r;
	logic [3:0]  op_r;
	logic        masked_r;
	logic [63:0] len_r;
	logic [63:0] rcvd_r;
	logic [7:0]  key_r [4];
	logic [1:0]  kidx;
	logic [1:0]  midx;
	logic [3:0]  ext_left;

	res_t pending_results [$];

	function automatic logic known_opcode(input logic [3:0] op);
		case (op)
			OPC_CONT, OPC_TEXT, OPC_BINARY, OPC_CLOSE, OPC_PING, OPC_PONG: return 1'b1;
			default: return 1'b0;
		endcase
	endfunction

	task automatic clear_frame();
		stage = P_FIRST;
		fin_r = 1'b0;
		op_r = '0;
		masked_r = 1'b0;
		len_r = '0;
		rcvd_r = '0;
		for (int i = 0; i < 4; i++)
			key_r[i] = '0;
		kidx = '0;
		midx = '0;
		ext_left = '0;
	endtask

	task automatic add_result(input logic [7:0] d, input logic h, input logic done,
			input status_t st);
		res_t r;
		r.payload = d;
		r.has = h;
		r.opcode = op_r;
		r.fin = fin_r;
		r.done = done;
		r.status = st;
		pending_results.push_back(r);
	endtask

	task automatic close_frame(input logic [7:0] d, input logic h);
		add_result(d, h, 1'b1, known_opcode(op_r) ? ST_OK : ST_BAD_OP);
		clear_frame();
	endtask

	task automatic start_payload();
		stage = P_DATA;
		rcvd_r = '0;
		midx = '0;
	endtask

	task automatic end_header();
		if (masked_r) begin
			stage = P_KEY;
			kidx = '0;
		end else if (len_r == 0) begin
			close_frame(8'h00, 1'b0);
		end else begin
			start_payload();
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		logic [6:0] l7;
		logic [7:0] d;
		l7 = b[6:0];
		case (stage)
			P_SECOND: begin
				masked_r = b[7];
				if (op_r[3] && l7 > LEN7_CTRL_MAX) begin
					add_result(8'h00, 1'b0, 1'b1, ST_CTRL_LEN);
					clear_frame();
				end else if (l7 == LEN7_EXT16) begin
					len_r = '0;
					ext_left = 4'd2;
					stage = P_EXTLEN;
				end else if (l7 == LEN7_EXT64) begin
					len_r = '0;
					ext_left = 4'd8;
					stage = P_EXTLEN;
				end else begin
					len_r = 64'(l7);
					end_header();
				end
			end
			P_EXTLEN: begin
				len_r = {len_r[55:0], b};
				ext_left = ext_left - 4'd1;
				if (ext_left == 0)
					end_header();
			end
			P_KEY: begin
				key_r[kidx] = b;
				if (kidx == KEY_LAST) begin
					if (len_r == 0)
						close_frame(8'h00, 1'b0);
					else
						start_payload();
				end else begin
					kidx = kidx + 2'd1;
				end
			end
			P_DATA: begin
				d = b ^ key_r[midx];
				midx = midx + 2'd1;
				rcvd_r = rcvd_r + 64'd1;
				if (rcvd_r == len_r)
					close_frame(d, 1'b1);
				else
					add_result(d, 1'b1, 1'b0, ST_OK);
			end
			default: begin
				fin_r = b[7];
				op_r = b[3:0];
				stage = P_SECOND;
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input res_t want);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t %s: expected payload=%02h has=%0d op=%0h fin=%0d done=%0d",
				$time, what, want.payload, want.has, want.opcode, want.fin, want.done,
				" status=%0d, got payload=%02h has=%0d op=%0h fin=%0d done=%0d",
				want.status, payload_byte, has_payload, frame_opcode, fin_flag, frame_done,
				" status=%0d", status_code);
	endtask

	always @(posedge clk or negedge arst_n) begin
		res_t want;
		if (!arst_n) begin
			clear_frame();
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					want = '0;
					note_mismatch("unexpected result transaction", want);
				end else begin
					want = pending_results.pop_front();
					if (payload_byte !== want.payload || has_payload !== want.has ||
							frame_opcode !== want.opcode || fin_flag !== want.fin ||
							frame_done !== want.done || status_code !== want.status)
						note_mismatch("result mismatch", want);
				end
			end
			if (push && !full)
				parse_byte(rx_byte);
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- dv/websocket_frame_parser_core_tb.sv -----
// testbench top for the websocket frame parser: byte stimulus, random stalls and verdict
module websocket_frame_parser_core_tb;
	import wfp_pkg::*;

	localparam int ITEMS = 1350;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 20;

	typedef enum logic [1:0] {
		FORM_7,
		FORM_16,
		FORM_64
	} lenform_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       pop = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       full;
	logic       empty;
	logic [7:0] payload_byte;
	logic       has_payload;
	logic [3:0] frame_opcode;
	logic       fin_flag;
	logic       frame_done;
	logic [1:0] status_code;

	int send_idle = 34;
	int recv_idle = 85;
	int bytes_sent = 0;
	int cycles = 0;
	int mismatches;
	int outstanding;

	websocket_frame_parser_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.payload_byte(payload_byte),
		.has_payload (has_payload),
		.frame_opcode(frame_opcode),
		.fin_flag    (fin_flag),
		.frame_done  (frame_done),
		.status_code (status_code)
	);

	websocket_frame_parser_core_chk u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.rx_byte     (rx_byte),
		.empty       (empty),
		.pop         (pop),
		.payload_byte(payload_byte),
		.has_payload (has_payload),
		.frame_opcode(frame_opcode),
		.fin_flag    (fin_flag),
		.frame_done  (frame_done),
		.status_code (status_code),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("websocket_frame_parser_core_tb NOT OK");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b);
		bit taken;
		while ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		rx_byte <= b;
		do begin
			@(negedge clk);
			taken = !full;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	task automatic send_frame(input logic [7:0] h0, input logic m, input int len,
			input lenform_t form);
		logic [63:0] len64;
		int nbytes;
		len64 = 64'(len);
		send_byte(h0);
		if (form == FORM_7) begin
			send_byte({m, len64[6:0]});
		end else begin
			send_byte({m, (form == FORM_16) ? LEN7_EXT16 : LEN7_EXT64});
			// oversized control frame stops at the second header byte
			if (h0[3])
				return;
			nbytes = (form == FORM_16) ? 2 : 8;
			for (int i = nbytes - 1; i >= 0; i--)
				send_byte(len64[8*i +: 8]);
		end
		if (m)
			repeat (4) send_byte(8'($urandom_range(255)));
		repeat (len) send_byte(8'($urandom_range(255)));
	endtask

	task automatic send_random_frame();
		int r;
		int len;
		logic [3:0] op;
		logic [2:0] rsv;
		lenform_t form;
		r = $urandom_range(99);
		len = ($urandom_range(15) == 0) ? $urandom_range(300) : $urandom_range(12);
		form = lenform_t'($urandom_range(2));
		rsv = 3'b000;
		if (r < 45) begin
			op = 4'($urandom_range(OPC_BINARY, OPC_CONT));
		end else if (r < 70) begin
			op = 4'($urandom_range(OPC_PONG, OPC_CLOSE));
			form = FORM_7;
			if (len > LEN7_CTRL_MAX)
				len = LEN7_CTRL_MAX;
		end else if (r < 80) begin
			if ($urandom_range(1))
				op = 4'($urandom_range(4'hF, OPC_PONG + 1));
			else
				op = 4'($urandom_range(OPC_CLOSE - 1, OPC_BINARY + 1));
		end else if (r < 88) begin
			op = 4'($urandom_range(4'hF, OPC_CLOSE));
			form = $urandom_range(1) ? FORM_16 : FORM_64;
		end else begin
			op = 4'($urandom_range(15));
			rsv = 3'($urandom_range(7));
		end
		if (form == FORM_7 && len > LEN7_CTRL_MAX)
			form = FORM_16;
		send_frame({1'($urandom_range(1)), rsv, op}, 1'($urandom_range(1)), len, form);
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// zero length, oversized control, unknown opcode, extended lengths
		send_frame(8'h81, 1'b0, 0, FORM_7);
		send_frame(8'h89, 1'b1, 5, FORM_16);
		send_frame(8'h0B, 1'b1, 1, FORM_7);
		send_frame(8'h02, 1'b0, 2, FORM_16);
		send_frame(8'hF0, 1'b1, 0, FORM_64);

		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 0) begin
				send_idle = 34;
				recv_idle = 85;
			end else if (ph == 1) begin
				send_idle = 85;
				recv_idle = 34;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			while (bytes_sent < (ph + 1) * ITEMS / 3)
				send_random_frame();
		end
		push <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("websocket_frame_parser_core_tb OK");
		else
			$display("websocket_frame_parser_core_tb NOT OK");
		$finish;
	end

endmodule
